FILE: hw/rtl/pfe_pkg.sv
// Shared types, token codes and status codes for the postfix expression evaluator.
package pfe_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 8;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int NUM_REGS    = 4;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [2:0]        opcode_t;
  typedef logic [1:0]        status_t;

  // Token codes.
  localparam opcode_t OP_PUSH_A = 3'd0;
  localparam opcode_t OP_PUSH_B = 3'd1;
  localparam opcode_t OP_PUSH_C = 3'd2;
  localparam opcode_t OP_PUSH_D = 3'd3;
  localparam opcode_t OP_ADD    = 3'd4;
  localparam opcode_t OP_SUB    = 3'd5;
  localparam opcode_t OP_MUL    = 3'd6;
  localparam opcode_t OP_DIV    = 3'd7;

  // Result status codes.
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;
  localparam status_t ST_DIVZERO   = 2'd3;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_VALUE_A = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_VALUE_B = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_VALUE_C = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_VALUE_D = 2'd3;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t quotient;
  } div_rsp_t;

endpackage

FILE: hw/rtl/postfix_expression_evaluator.sv
// Top level: token sequencer around the operand stack RAM and the divider.
// A push is written to the stack from the idle state; add, subtract and multiply read
// the newer operand, then the older one, compute and write back. A divide waits for the
// divider, at one quotient bit per cycle. An end-of-expression token then reads the top
// of the stack, waiting while the previous result is held in the output register.
// Reset (synchronous, active low) empties the stack, clears the error and the registers.
module postfix_expression_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  // Input tokens.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] opcode, [7:3] zero
  input  logic        in_tlast,   // end_of_expression
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [1:0]  out_tuser,  // [1:0] status
  // Configuration.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD_Y = 3'd1;
  localparam logic [2:0] S_OPER = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  localparam int CW = pfe_pkg::CNT_W;
  localparam int AW = pfe_pkg::ADDR_W;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  pfe_pkg::status_t         err_r, err_nxt;
  pfe_pkg::opcode_t         op_r, op_nxt;
  logic                     last_r, last_nxt;
  pfe_pkg::word_t           x_r, x_nxt;
  pfe_pkg::word_t           res_r, res_nxt;
  pfe_pkg::word_t           out_data_r, out_data_nxt;
  pfe_pkg::status_t         out_stat_r, out_stat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  pfe_pkg::word_t           val_r [pfe_pkg::NUM_REGS];

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  pfe_pkg::word_t           wr_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  pfe_pkg::word_t           rd_data;

  pfe_pkg::div_req_t        div_req;
  pfe_pkg::div_rsp_t        div_rsp;

  logic [CW-1:0]            cnt_m1;
  logic [CW-1:0]            cnt_m2;
  pfe_pkg::opcode_t         in_op;
  pfe_pkg::status_t         fin_stat;
  pfe_pkg::word_t           product;

  assign cnt_m1  = cnt_r - CW'(1);
  assign cnt_m2  = cnt_r - CW'(2);
  assign in_op   = in_tdata[2:0];
  assign product = rd_data * x_r;

  // An explicit error wins; otherwise an empty stack at the end is an underflow.
  assign fin_stat = (err_r != pfe_pkg::ST_OK) ? err_r :
                    (cnt_r == '0) ? pfe_pkg::ST_UNDERFLOW : pfe_pkg::ST_OK;

  pfe_stack_ram #(
    .DEPTH (pfe_pkg::STACK_DEPTH),
    .WIDTH (pfe_pkg::DATA_W),
    .ADDR_W(AW)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  pfe_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    x_nxt         = x_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = val_r[in_op[1:0]];
    rd_en         = 1'b0;
    rd_addr       = cnt_m1[AW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = rd_data;
    div_req.divisor  = x_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = in_op;
          last_nxt = in_tlast;
          if (in_op < pfe_pkg::OP_ADD) begin
            if (cnt_r < CW'(pfe_pkg::STACK_DEPTH)) begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end else if (err_r == pfe_pkg::ST_OK) begin
              err_nxt = pfe_pkg::ST_OVERFLOW;
            end
            state_nxt = in_tlast ? S_FIN : S_IDLE;
          end else if (cnt_r < CW'(2)) begin
            if (err_r == pfe_pkg::ST_OK) begin
              err_nxt = pfe_pkg::ST_UNDERFLOW;
            end
            state_nxt = in_tlast ? S_FIN : S_IDLE;
          end else begin
            // Fetch the newer operand now, the older one in the next cycle.
            rd_en     = 1'b1;
            state_nxt = S_RD_Y;
          end
        end
      end
      S_RD_Y: begin
        rd_en     = 1'b1;
        rd_addr   = cnt_m2[AW-1:0];
        x_nxt     = rd_data;
        state_nxt = S_OPER;
      end
      S_OPER: begin
        state_nxt = S_WB;
        case (op_r)
          pfe_pkg::OP_ADD: res_nxt = rd_data + x_r;
          pfe_pkg::OP_SUB: res_nxt = rd_data - x_r;
          pfe_pkg::OP_MUL: res_nxt = product;
          default: begin
            if (x_r == '0) begin
              res_nxt = '0;
              if (err_r == pfe_pkg::ST_OK) begin
                err_nxt = pfe_pkg::ST_DIVZERO;
              end
            end else begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_nxt   = div_rsp.quotient;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        // Two operands popped, one result pushed in the lower slot.
        wr_en     = 1'b1;
        wr_addr   = cnt_m2[AW-1:0];
        wr_data   = res_r;
        cnt_nxt   = cnt_m1;
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        rd_en     = 1'b1;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = fin_stat;
          out_data_nxt  = (fin_stat == pfe_pkg::ST_OK) ? rd_data : '0;
          cnt_nxt       = '0;
          err_nxt       = pfe_pkg::ST_OK;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= pfe_pkg::ST_OK;
      out_valid_r <= 1'b0;
      for (int i = 0; i < pfe_pkg::NUM_REGS; i++) begin
        val_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pfe_pkg::REG_VALUE_A: val_r[pfe_pkg::REG_VALUE_A] <= cfg_wdata;
          pfe_pkg::REG_VALUE_B: val_r[pfe_pkg::REG_VALUE_B] <= cfg_wdata;
          pfe_pkg::REG_VALUE_C: val_r[pfe_pkg::REG_VALUE_C] <= cfg_wdata;
          pfe_pkg::REG_VALUE_D: val_r[pfe_pkg::REG_VALUE_D] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    last_r     <= last_nxt;
    x_r        <= x_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  // The fill count never goes past the stack depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(pfe_pkg::STACK_DEPTH))
    else $error("stack count exceeds depth");

  // The first error of an expression holds until its result is produced.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != pfe_pkg::ST_OK && state_r != S_RES) |=> (err_r == $past(err_r)))
    else $error("error code changed inside an expression");

  // The divider is only started when it is free, and only from the operator state.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (!div_rsp.busy && state_r == S_OPER))
    else $error("divider started while busy");

  // An operator reaches write-back only with two operands on the stack.
  a_wb_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> (cnt_r >= CW'(2)))
    else $error("write-back without two operands");

endmodule

FILE: hw/rtl/pfe_stack_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pfe_stack_ram #(
  parameter int DEPTH  = 8,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/pfe_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pfe_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  pfe_pkg::div_req_t req,
  output pfe_pkg::div_rsp_t rsp
);

  localparam int STEP_W = $clog2(pfe_pkg::DATA_W);

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic                neg_r;
  pfe_pkg::word_t      rem_r;
  pfe_pkg::word_t      quo_r;
  pfe_pkg::word_t      dvs_r;

  pfe_pkg::word_t      dvd_abs;
  pfe_pkg::word_t      dvs_abs;
  logic [pfe_pkg::DATA_W:0] shifted;
  logic [pfe_pkg::DATA_W:0] trial;
  pfe_pkg::word_t      rem_nxt;
  pfe_pkg::word_t      quo_nxt;

  // The most negative value keeps its bit pattern here, which is its magnitude unsigned.
  assign dvd_abs = req.dividend[pfe_pkg::DATA_W-1] ?
                   (~req.dividend + pfe_pkg::DATA_W'(1)) : req.dividend;
  assign dvs_abs = req.divisor[pfe_pkg::DATA_W-1] ?
                   (~req.divisor + pfe_pkg::DATA_W'(1)) : req.divisor;

  always_comb begin
    shifted = {rem_r, quo_r[pfe_pkg::DATA_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    if (!trial[pfe_pkg::DATA_W]) begin
      rem_nxt = trial[pfe_pkg::DATA_W-1:0];
      quo_nxt = {quo_r[pfe_pkg::DATA_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[pfe_pkg::DATA_W-1:0];
      quo_nxt = {quo_r[pfe_pkg::DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(pfe_pkg::DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= dvd_abs;
      dvs_r <= dvs_abs;
      neg_r <= req.dividend[pfe_pkg::DATA_W-1] ^ req.divisor[pfe_pkg::DATA_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (~quo_r + pfe_pkg::DATA_W'(1)) : quo_r;

endmodule
